[rtl/tgai_pkg.sv]
`default_nettype none
package tgai_pkg;

  localparam logic [1:0] KIND_SWAP       = 2'd0;
  localparam logic [1:0] KIND_FINAL      = 2'd1;
  localparam logic [1:0] KIND_ITEMS_FULL = 2'd2;
  localparam logic [1:0] KIND_TABLE_FULL = 2'd3;

  localparam int IDX_W = 10;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_SRCH = 3'b010,
    S_WALK = 3'b100
  } state_t;

  typedef struct packed {
    logic             valid;
    logic [1:0]       kind;
    logic [IDX_W-1:0] first;
    logic [IDX_W-1:0] second;
    logic             last;
  } result_t;

endpackage
`default_nettype wire

[rtl/type_grouped_array_insert.sv]
// Each insert runs a newest-first key search, one compare per cycle, and on a match an end
// walk through the table RAMs, one entry per cycle; start is taken only while busy is low.
// A store-full reject keeps busy low; a table-full reject ends the search.
// Reset clears the item and group counts; table contents stay undefined until written.
// Results are strobed for one cycle each, one per cycle; the receiver cannot stall.
`default_nettype none
module type_grouped_array_insert #(
  parameter int MAX_GROUPS = 16,
  parameter int MAX_ITEMS  = 1024
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire logic [31:0] type_key,
  output logic             busy,
  output logic             strobe,
  output logic [1:0]       result_kind,
  output logic [9:0]       first_index,
  output logic [9:0]       second_index,
  output logic             is_last
);

  localparam int GW = (MAX_GROUPS > 1) ? $clog2(MAX_GROUPS) : 1;
  localparam int IW = $clog2(MAX_ITEMS + 1);

  logic          key_we;
  logic [GW-1:0] key_waddr;
  logic [31:0]   key_wdata;
  logic [GW-1:0] key_raddr;
  logic [31:0]   key_rdata;
  logic          end_we;
  logic [GW-1:0] end_waddr;
  logic [IW-1:0] end_wdata;
  logic [GW-1:0] end_raddr;
  logic [IW-1:0] end_rdata;

  tgai_pkg::result_t res;

  tgai_ctrl #(
    .MAX_GROUPS (MAX_GROUPS),
    .MAX_ITEMS  (MAX_ITEMS)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .type_key  (type_key),
    .busy      (busy),
    .key_we    (key_we),
    .key_waddr (key_waddr),
    .key_wdata (key_wdata),
    .key_raddr (key_raddr),
    .key_rdata (key_rdata),
    .end_we    (end_we),
    .end_waddr (end_waddr),
    .end_wdata (end_wdata),
    .end_raddr (end_raddr),
    .end_rdata (end_rdata),
    .res       (res)
  );

  tgai_ram #(
    .WIDTH (32),
    .DEPTH (MAX_GROUPS)
  ) u_key_ram (
    .clk   (clk),
    .we    (key_we),
    .waddr (key_waddr),
    .wdata (key_wdata),
    .raddr (key_raddr),
    .rdata (key_rdata)
  );

  tgai_ram #(
    .WIDTH (IW),
    .DEPTH (MAX_GROUPS)
  ) u_end_ram (
    .clk   (clk),
    .we    (end_we),
    .waddr (end_waddr),
    .wdata (end_wdata),
    .raddr (end_raddr),
    .rdata (end_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      strobe <= 1'b0;
    end else begin
      strobe <= res.valid;
    end
    result_kind  <= res.kind;
    first_index  <= res.first;
    second_index <= res.second;
    is_last      <= res.last;
  end

  a_last_idle: assert property (@(posedge clk) disable iff (rst)
    strobe && is_last |-> !busy)
    else $error("last result while still busy");

  a_nonswap_last: assert property (@(posedge clk) disable iff (rst)
    strobe && (result_kind != tgai_pkg::KIND_SWAP) |-> is_last)
    else $error("non-swap result not marked last");

  a_reject_zero: assert property (@(posedge clk) disable iff (rst)
    strobe && (result_kind == tgai_pkg::KIND_ITEMS_FULL ||
               result_kind == tgai_pkg::KIND_TABLE_FULL)
    |-> (first_index == '0) && (second_index == '0))
    else $error("reject result with nonzero indices");

  a_start_acts: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy || strobe)
    else $error("start transfer ignored");

endmodule
`default_nettype wire

[rtl/tgai_ram.sv]
`default_nettype none
module tgai_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic                    clk,
  input  wire logic                    we,
  input  wire logic [AW-1:0]           waddr,
  input  wire logic [WIDTH-1:0]        wdata,
  input  wire logic [AW-1:0]           raddr,
  output logic      [WIDTH-1:0]        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

[rtl/tgai_ctrl.sv]
`default_nettype none
module tgai_ctrl #(
  parameter int MAX_GROUPS = 16,
  parameter int MAX_ITEMS  = 1024,
  localparam int GW = (MAX_GROUPS > 1) ? $clog2(MAX_GROUPS) : 1,
  localparam int IW = $clog2(MAX_ITEMS + 1)
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  input  wire logic [31:0]      type_key,
  output logic                  busy,
  output logic                  key_we,
  output logic [GW-1:0]         key_waddr,
  output logic [31:0]           key_wdata,
  output logic [GW-1:0]         key_raddr,
  input  wire logic [31:0]      key_rdata,
  output logic                  end_we,
  output logic [GW-1:0]         end_waddr,
  output logic [IW-1:0]         end_wdata,
  output logic [GW-1:0]         end_raddr,
  input  wire logic [IW-1:0]    end_rdata,
  output tgai_pkg::result_t     res
);

  localparam int CW = $clog2(MAX_GROUPS + 1);
  localparam int XW = IW + tgai_pkg::IDX_W;

  tgai_pkg::state_t state;

  logic [31:0]   key;
  logic [IW-1:0] src;
  logic [IW-1:0] item_total;
  logic [CW-1:0] gcount;
  logic [CW-1:0] left;
  logic          pend_v;
  logic [GW-1:0] pend_idx;
  logic [GW-1:0] g;
  logic [GW-1:0] hit;
  logic [IW-1:0] fin;

  logic          match;
  logic          last_g;
  logic          new_ok;
  logic          notfound;
  logic          items_full;
  logic [IW-1:0] d;
  logic [IW-1:0] first_sel;
  logic [XW-1:0] first_ext;
  logic [XW-1:0] src_ext;

  assign busy       = (state != tgai_pkg::S_IDLE);
  assign d          = end_rdata;
  assign match      = pend_v && (key_rdata == key);
  assign last_g     = (CW'(g) == (gcount - CW'(1)));
  assign new_ok     = (gcount < CW'(MAX_GROUPS));
  assign items_full = (item_total >= IW'(MAX_ITEMS));
  assign notfound   = (state == tgai_pkg::S_SRCH) && !match && (left == '0);

  assign key_raddr = GW'(left - CW'(1));
  assign key_we    = notfound && new_ok;
  assign key_waddr = GW'(gcount);
  assign key_wdata = key;

  assign end_raddr = (state == tgai_pkg::S_SRCH) ? pend_idx : GW'(g + GW'(1));
  assign end_we    = key_we || (state == tgai_pkg::S_WALK);
  assign end_waddr = (state == tgai_pkg::S_WALK) ? g : GW'(gcount);
  assign end_wdata = (state == tgai_pkg::S_WALK) ? d + IW'(1) : src + IW'(1);

  assign first_ext = {{tgai_pkg::IDX_W{1'b0}}, first_sel};
  assign src_ext   = {{tgai_pkg::IDX_W{1'b0}}, src};

  always_comb begin
    res       = '0;
    first_sel = d;
    unique case (state)
      tgai_pkg::S_IDLE: begin
        if (start && items_full) begin
          res.valid = 1'b1;
          res.kind  = tgai_pkg::KIND_ITEMS_FULL;
          res.last  = 1'b1;
        end
      end
      tgai_pkg::S_SRCH: begin
        first_sel = src;
        if (notfound) begin
          res.valid = 1'b1;
          res.last  = 1'b1;
          if (new_ok) begin
            res.kind  = tgai_pkg::KIND_FINAL;
            res.first = first_ext[tgai_pkg::IDX_W-1:0];
          end else begin
            res.kind  = tgai_pkg::KIND_TABLE_FULL;
          end
        end
      end
      tgai_pkg::S_WALK: begin
        if (last_g) begin
          first_sel = (g == hit) ? d : fin;
          res.valid = 1'b1;
          res.kind  = tgai_pkg::KIND_FINAL;
          res.first = first_ext[tgai_pkg::IDX_W-1:0];
          res.last  = 1'b1;
        end else if (d != src) begin
          res.valid  = 1'b1;
          res.kind   = tgai_pkg::KIND_SWAP;
          res.first  = first_ext[tgai_pkg::IDX_W-1:0];
          res.second = src_ext[tgai_pkg::IDX_W-1:0];
        end
      end
      default: begin
        res = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= tgai_pkg::S_IDLE;
      gcount     <= '0;
      item_total <= '0;
      pend_v     <= 1'b0;
    end else begin
      unique case (state)
        tgai_pkg::S_IDLE: begin
          if (start && !items_full) begin
            key    <= type_key;
            src    <= item_total;
            left   <= gcount;
            pend_v <= 1'b0;
            state  <= tgai_pkg::S_SRCH;
          end
        end
        tgai_pkg::S_SRCH: begin
          // search runs newest entry first, one compare per cycle
          if (match) begin
            hit   <= pend_idx;
            g     <= pend_idx;
            state <= tgai_pkg::S_WALK;
          end else if (left == '0) begin
            if (new_ok) begin
              gcount     <= gcount + CW'(1);
              item_total <= item_total + IW'(1);
            end
            state <= tgai_pkg::S_IDLE;
          end else begin
            pend_v   <= 1'b1;
            pend_idx <= GW'(left - CW'(1));
            left     <= left - CW'(1);
          end
        end
        tgai_pkg::S_WALK: begin
          if (g == hit) begin
            fin <= d;
          end
          if (last_g) begin
            item_total <= item_total + IW'(1);
            state      <= tgai_pkg::S_IDLE;
          end else begin
            g <= g + GW'(1);
          end
        end
        default: begin
          state <= tgai_pkg::S_IDLE;
        end
      endcase
    end
  end

endmodule
`default_nettype wire
